FILE: rtl/slab_chunk_allocator_assert.svh
// Assertion macros shared by the slab chunk allocator RTL.
// Included by the files that check their own logic; no other dependencies.
`ifndef SLAB_CHUNK_ALLOCATOR_ASSERT_SVH
`define SLAB_CHUNK_ALLOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slab chunk allocator check failed");

// The consequent must hold in the cycle after the antecedent.
`define SCA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slab chunk allocator check failed");

`endif

FILE: rtl/sca_pkg.sv
// Shared constants, types and helpers of the slab chunk allocator.
// Used by every module of the block; depends on nothing.
package sca_pkg;

  localparam int MAX_BLOCKS  = 1024;
  localparam int BLK_W       = 10;
  localparam int PTR_W       = 11;
  localparam int NUM_CLASSES = 9;
  localparam int CLS_W       = 4;
  localparam int MAX_CHUNKS  = 256;
  localparam int CHUNK_W     = 8;
  localparam int SEG_W       = 32;
  localparam int SEG_BIT_W   = 5;
  localparam int NUM_SEGS    = MAX_CHUNKS / SEG_W;
  localparam int SEG_IDX_W   = 3;
  localparam int OFF_W       = 26;

  localparam logic [PTR_W-1:0] NIL = '1;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_SIZE   = 3'd1;
  localparam logic [2:0] ST_NO_BLOCK   = 3'd2;
  localparam logic [2:0] ST_FREE_RANGE = 3'd4;

  localparam logic [1:0] REG_BLOCK_SHIFT     = 2'd0;
  localparam logic [1:0] REG_MIN_CHUNK_SHIFT = 2'd1;
  localparam logic [1:0] REG_BLOCK_COUNT     = 2'd2;

  typedef struct packed {
    logic [4:0]  bs;
    logic [4:0]  mcs;
    logic [10:0] nblk;
  } geom_t;

  typedef struct packed {
    logic [CLS_W-1:0] cls;
    logic             full;
    logic [PTR_W-1:0] prev;
    logic [PTR_W-1:0] next;
  } meta_t;

  typedef struct packed {
    logic             start;
    logic             invert;
    logic [CHUNK_W:0] nchunks;
  } scan_ctl_t;

  typedef struct packed {
    logic               done;
    logic               any;
    logic               multi;
    logic [CHUNK_W-1:0] first;
  } scan_res_t;

  typedef struct packed {
    logic             valid;
    logic [BLK_W-1:0] addr;
    logic             set_next;
    logic [PTR_W-1:0] value;
  } patch_t;

  // Block numbers at or above the block limit mean "no block".
  function automatic logic ptr_valid(input logic [PTR_W-1:0] p);
    return !p[PTR_W-1];
  endfunction

endpackage

FILE: rtl/sca_cfg_regs.sv
// Configuration registers of the slab chunk allocator and the clamped geometry.
// Depends on sca_pkg.
module sca_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output sca_pkg::geom_t geom
);
  import sca_pkg::*;

  localparam logic [4:0]  BS_RESET   = 5'd12;
  localparam logic [4:0]  MCS_RESET  = 5'd5;
  localparam logic [10:0] CNT_RESET  = 11'd1024;
  localparam logic [4:0]  SHIFT_MIN  = 5'd3;
  localparam logic [4:0]  BS_MAX     = 5'd16;
  localparam logic [4:0]  SPAN_MAX   = 5'd8;
  localparam logic [10:0] CNT_MAX    = 11'(MAX_BLOCKS);

  logic [4:0]  bs_r, mcs_r;
  logic [10:0] cnt_r;
  logic [1:0]  idx;
  logic        wr;
  logic [4:0]  bs, mcs;

  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_r  <= BS_RESET;
      mcs_r <= MCS_RESET;
      cnt_r <= CNT_RESET;
    end else if (wr) begin
      unique case (idx)
        REG_BLOCK_SHIFT:     bs_r  <= pwdata[4:0];
        REG_MIN_CHUNK_SHIFT: mcs_r <= pwdata[4:0];
        REG_BLOCK_COUNT:     cnt_r <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_BLOCK_SHIFT:     prdata = {27'b0, bs_r};
      REG_MIN_CHUNK_SHIFT: prdata = {27'b0, mcs_r};
      REG_BLOCK_COUNT:     prdata = {21'b0, cnt_r};
      default:             prdata = '0;
    endcase
  end

  // The chunk size may lie at most eight octaves below the block size.
  always_comb begin
    bs = bs_r;
    if (bs < SHIFT_MIN) bs = SHIFT_MIN;
    if (bs > BS_MAX) bs = BS_MAX;
    mcs = mcs_r;
    if (mcs < SHIFT_MIN) mcs = SHIFT_MIN;
    if (mcs > bs) mcs = bs;
    if (bs - mcs > SPAN_MAX) mcs = bs - SPAN_MAX;
    geom.bs   = bs;
    geom.mcs  = mcs;
    geom.nblk = (cnt_r == 11'd0) ? 11'd1 : ((cnt_r > CNT_MAX) ? CNT_MAX : cnt_r);
  end

endmodule

FILE: rtl/sca_scan.sv
// Bitmap scanner of the slab chunk allocator: walks a block bitmap one segment a cycle.
// Depends on sca_pkg.
module sca_scan (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sca_pkg::scan_ctl_t            ctl,
  input  logic [sca_pkg::MAX_CHUNKS-1:0] vec,
  output sca_pkg::scan_res_t            res
);
  import sca_pkg::*;

  logic                 busy_r, done_r, any_r, multi_r;
  logic [SEG_IDX_W-1:0] seg_r;
  logic [CHUNK_W-1:0]   first_r;
  logic [SEG_W-1:0]     word, mask, w;
  logic                 seg_any, seg_multi;
  logic [SEG_BIT_W-1:0] seg_low;

  function automatic logic [SEG_BIT_W-1:0] low_idx(input logic [SEG_W-1:0] v);
    logic [SEG_W-1:0]     oh;
    logic [SEG_BIT_W-1:0] r;
    oh = v & (~v + SEG_W'(1));
    r  = '0;
    for (int k = 0; k < SEG_W; k++) begin
      if (oh[k]) r = r | SEG_BIT_W'(k);
    end
    return r;
  endfunction

  // Bits at or beyond the chunk count of the block take no part.
  always_comb begin
    word = vec[{seg_r, SEG_BIT_W'(0)} +: SEG_W];
    for (int i = 0; i < SEG_W; i++) begin
      mask[i] = ({1'b0, seg_r, SEG_BIT_W'(i)} < ctl.nchunks);
    end
    w         = (ctl.invert ? ~word : word) & mask;
    seg_any   = |w;
    seg_multi = |(w & (w - SEG_W'(1)));
    seg_low   = low_idx(w);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      seg_r   <= '0;
      any_r   <= 1'b0;
      multi_r <= 1'b0;
      first_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r  <= 1'b1;
        seg_r   <= '0;
        any_r   <= 1'b0;
        multi_r <= 1'b0;
        first_r <= '0;
      end else if (busy_r) begin
        if (!any_r && seg_any) first_r <= {seg_r, seg_low};
        multi_r <= multi_r | seg_multi | (any_r & seg_any);
        any_r   <= any_r | seg_any;
        if (seg_r == SEG_IDX_W'(NUM_SEGS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          seg_r <= seg_r + SEG_IDX_W'(1);
        end
      end
    end
  end

  assign res.done  = done_r;
  assign res.any   = any_r;
  assign res.multi = multi_r;
  assign res.first = first_r;

endmodule

FILE: rtl/slab_chunk_allocator.sv
// Slab chunk allocator top level: sequencer, block tables and list heads.
// Depends on sca_pkg, sca_cfg_regs, sca_scan and slab_chunk_allocator_assert.svh.
//
// Usage: an item on the in_ channel is accepted when in_valid is high and
// in_stall is low. in_op selects allocate (in_alloc_size) or free
// (in_free_offset). Each item gives one result on the out_ channel: a status
// and, for a successful allocate, the byte offset of the chunk.
// One item is handled at a time; in_stall stays high while it is at work.
// An allocate that reads the block tables and a free first read the block
// entry; an allocate by bump pointer skips that read. The bitmap scanner then
// passes over the 256 chunk bits in 32-bit segments and reports, and the
// three list patch slots are visited; each list neighbour patched through the
// single-port block table is read and then written back. A failed size check
// or an out-of-range free answers straight after decode, an allocate with no
// block left after block selection. The next item can be accepted as soon as
// out_valid rises. A finished result waits in the output register while
// out_stall is high; the next item may be accepted meanwhile, and its result
// is held back until the register is free. Reset empties all lists and the
// bump pointer, and restores the configuration registers; block entries
// above the bump pointer are never read, so no clearing pass follows reset.
// The user must write configuration over the APB port only while the block
// is idle; the block itself does not enforce it.
module slab_chunk_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [16:0] in_alloc_size,
  input  logic [25:0] in_free_offset,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [25:0] out_chunk_offset,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sca_pkg::*;
  `include "slab_chunk_allocator_assert.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_SEL, S_RD, S_LOAD, S_SCAN, S_POST, S_WSELF, S_PRD, S_PWR, S_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic               op_r;
  logic [16:0]        size_r;
  logic [OFF_W-1:0]   off_r;
  logic [BLK_W-1:0]   blk_r, blk_nxt;
  logic [CLS_W-1:0]   cls_r, cls_nxt;
  logic               fresh_r, fresh_nxt;
  meta_t              meta_r, meta_nxt;
  logic [MAX_CHUNKS-1:0] bm_r, bm_nxt;
  logic [2:0]         status_r, status_nxt;
  logic [OFF_W-1:0]   chunk_r, chunk_nxt;
  patch_t             patch_r [3];
  patch_t             patch_nxt [3];
  logic [1:0]         pidx_r, pidx_nxt;
  logic [PTR_W-1:0]   next_unused_r, next_unused_nxt;
  logic [PTR_W-1:0]   class_head_r [NUM_CLASSES];
  logic [PTR_W-1:0]   class_head_nxt [NUM_CLASSES];
  logic [PTR_W-1:0]   empty_head_r, empty_head_nxt;
  logic [PTR_W-1:0]   full_head_r, full_head_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [2:0]         out_status_r, out_status_nxt;
  logic [OFF_W-1:0]   out_chunk_r, out_chunk_nxt;

  geom_t              geom;
  scan_ctl_t          scan_ctl;
  scan_res_t          scan_res;
  logic               scan_go;

  meta_t              meta_mem [MAX_BLOCKS];
  logic [MAX_CHUNKS-1:0] bm_mem [MAX_BLOCKS];
  meta_t              meta_rd_r, meta_wdata, patched;
  logic [MAX_CHUNKS-1:0] bm_rd_r;
  logic [BLK_W-1:0]   mem_addr;
  logic               meta_we, bm_we;

  logic [CLS_W-1:0]   top_cls;

  sca_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .geom   (geom)
  );

  sca_scan u_scan (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (scan_ctl),
    .vec  (bm_r),
    .res  (scan_res)
  );

  assign top_cls         = CLS_W'(geom.bs - geom.mcs);
  assign scan_ctl.start  = scan_go;
  assign scan_ctl.invert = !op_r;
  assign scan_ctl.nchunks = (CHUNK_W + 1)'(1) << (top_cls - cls_r);

  function automatic logic [4:0] msb_index(input logic [16:0] v);
    logic [4:0] r;
    r = '0;
    for (int k = 0; k < 17; k++) begin
      if (v[k]) r = 5'(k);
    end
    return r;
  endfunction

  // Block table: one port, read data registered.
  assign mem_addr = (state_r == S_PRD || state_r == S_PWR) ? patch_r[pidx_r].addr : blk_r;
  assign meta_we  = (state_r == S_WSELF) || (state_r == S_PWR);
  assign bm_we    = (state_r == S_WSELF);

  always_comb begin
    patched = meta_rd_r;
    if (patch_r[pidx_r].set_next) patched.next = patch_r[pidx_r].value;
    else patched.prev = patch_r[pidx_r].value;
    meta_wdata = (state_r == S_WSELF) ? meta_r : patched;
  end

  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[mem_addr] <= meta_wdata;
    meta_rd_r <= meta_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (bm_we) bm_mem[blk_r] <= bm_r;
    bm_rd_r <= bm_mem[blk_r];
  end

  always_comb begin
    logic [16:0]      size_m1, shifted;
    logic [4:0]       c_raw;
    logic             bad;
    logic [OFF_W-1:0] bidx_full, bsmask, jw;
    logic [CLS_W-1:0] cl;
    logic [CHUNK_W-1:0] pick, j;
    logic [PTR_W-1:0] head, nx, p, n, g_old;
    logic             full, empty, was_full, active;
    logic             unl_full, unl_cls, push_empty, push_cls;

    state_nxt       = state_r;
    blk_nxt         = blk_r;
    cls_nxt         = cls_r;
    fresh_nxt       = fresh_r;
    meta_nxt        = meta_r;
    bm_nxt          = bm_r;
    status_nxt      = status_r;
    chunk_nxt       = chunk_r;
    pidx_nxt        = pidx_r;
    next_unused_nxt = next_unused_r;
    empty_head_nxt  = empty_head_r;
    full_head_nxt   = full_head_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_status_nxt  = out_status_r;
    out_chunk_nxt   = out_chunk_r;
    scan_go         = 1'b0;
    for (int k = 0; k < 3; k++) patch_nxt[k] = patch_r[k];
    for (int k = 0; k < NUM_CLASSES; k++) class_head_nxt[k] = class_head_r[k];

    size_m1   = size_r - 17'd1;
    shifted   = size_m1 >> (geom.mcs - 5'd1);
    c_raw     = msb_index(shifted);
    bad       = (size_r == 17'd0) || (size_r > (17'd1 << geom.bs));
    bidx_full = off_r >> geom.bs;
    bsmask    = (OFF_W'(1) << geom.bs) - OFF_W'(1);
    cl        = (meta_rd_r.cls > top_cls) ? top_cls : meta_rd_r.cls;
    jw        = (off_r & bsmask) >> 5'(geom.mcs + 5'(cl));
    j         = jw[CHUNK_W-1:0];
    head      = class_head_r[cls_r];
    pick      = scan_res.any ? scan_res.first : '0;
    full      = !scan_res.multi;
    empty     = !scan_res.any;
    was_full  = meta_r.full;
    nx        = meta_r.next;
    p         = meta_r.prev;
    n         = meta_r.next;
    g_old     = NIL;
    active    = 1'b0;
    unl_full  = 1'b0;
    unl_cls   = 1'b0;
    push_empty = 1'b0;
    push_cls  = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DEC;
      end
      S_DEC: begin
        status_nxt = ST_OK;
        chunk_nxt  = '0;
        for (int k = 0; k < 3; k++) patch_nxt[k] = '0;
        if (!op_r) begin
          if (bad) begin
            status_nxt = ST_BAD_SIZE;
            state_nxt  = S_DONE;
          end else begin
            cls_nxt   = (c_raw > 5'(top_cls)) ? top_cls : c_raw[CLS_W-1:0];
            state_nxt = S_SEL;
          end
        end else if (bidx_full >= OFF_W'(next_unused_r)) begin
          status_nxt = ST_FREE_RANGE;
          state_nxt  = S_DONE;
        end else begin
          blk_nxt   = bidx_full[BLK_W-1:0];
          state_nxt = S_RD;
        end
      end
      S_SEL: begin
        // A block taken by bump pointer has never been set up, so its bitmap
        // is known to be clear without a read.
        if (ptr_valid(head)) begin
          blk_nxt   = head[BLK_W-1:0];
          fresh_nxt = 1'b0;
          state_nxt = S_RD;
        end else if (ptr_valid(empty_head_r)) begin
          blk_nxt   = empty_head_r[BLK_W-1:0];
          fresh_nxt = 1'b1;
          state_nxt = S_RD;
        end else if (next_unused_r < geom.nblk) begin
          blk_nxt         = next_unused_r[BLK_W-1:0];
          next_unused_nxt = next_unused_r + PTR_W'(1);
          meta_nxt        = '{cls: cls_r, full: 1'b0, prev: NIL, next: NIL};
          bm_nxt          = '0;
          class_head_nxt[cls_r] = next_unused_r;
          scan_go         = 1'b1;
          state_nxt       = S_SCAN;
        end else begin
          status_nxt = ST_NO_BLOCK;
          state_nxt  = S_DONE;
        end
      end
      S_RD: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (!op_r) begin
          if (fresh_r) begin
            empty_head_nxt = meta_rd_r.next;
            if (ptr_valid(meta_rd_r.next)) begin
              patch_nxt[0] = '{valid: 1'b1, addr: meta_rd_r.next[BLK_W-1:0],
                               set_next: 1'b0, value: NIL};
            end
            meta_nxt = '{cls: cls_r, full: 1'b0, prev: NIL, next: NIL};
            bm_nxt   = '0;
            class_head_nxt[cls_r] = {1'b0, blk_r};
          end else begin
            meta_nxt = meta_rd_r;
            bm_nxt   = bm_rd_r;
          end
        end else begin
          cls_nxt  = cl;
          meta_nxt = meta_rd_r;
          bm_nxt   = bm_rd_r & ~(MAX_CHUNKS'(1) << j);
        end
        scan_go   = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (scan_res.done) state_nxt = S_POST;
      end
      S_POST: begin
        if (!op_r) begin
          bm_nxt    = bm_r | (MAX_CHUNKS'(1) << pick);
          chunk_nxt = (OFF_W'(blk_r) << geom.bs) +
                      (OFF_W'(pick) << 5'(geom.mcs + 5'(cls_r)));
          if (full) begin
            class_head_nxt[cls_r] = nx;
            if (ptr_valid(nx)) begin
              patch_nxt[1] = '{valid: 1'b1, addr: nx[BLK_W-1:0], set_next: 1'b0, value: NIL};
            end
            if (ptr_valid(full_head_r)) begin
              patch_nxt[2] = '{valid: 1'b1, addr: full_head_r[BLK_W-1:0],
                               set_next: 1'b0, value: {1'b0, blk_r}};
            end
            meta_nxt      = '{cls: meta_r.cls, full: 1'b1, prev: NIL, next: full_head_r};
            full_head_nxt = {1'b0, blk_r};
          end
        end else begin
          meta_nxt.full = 1'b0;
          unl_full   = was_full;
          unl_cls    = !was_full && empty;
          push_empty = empty;
          push_cls   = was_full && !empty;
          active     = was_full || empty;
          g_old      = push_empty ? empty_head_r : head;
          if (active) begin
            // Take the block out of its list; the old heads are distinct lists.
            if (ptr_valid(p)) begin
              patch_nxt[0] = '{valid: 1'b1, addr: p[BLK_W-1:0], set_next: 1'b1, value: n};
            end else if (unl_full) begin
              full_head_nxt = n;
            end else if (unl_cls) begin
              class_head_nxt[cls_r] = n;
            end
            if (ptr_valid(n)) begin
              patch_nxt[1] = '{valid: 1'b1, addr: n[BLK_W-1:0], set_next: 1'b0, value: p};
            end
            meta_nxt.prev = NIL;
            meta_nxt.next = g_old;
            if (push_empty) empty_head_nxt = {1'b0, blk_r};
            if (push_cls) class_head_nxt[cls_r] = {1'b0, blk_r};
            if (ptr_valid(g_old)) begin
              patch_nxt[2] = '{valid: 1'b1, addr: g_old[BLK_W-1:0],
                               set_next: 1'b0, value: {1'b0, blk_r}};
            end
          end
        end
        state_nxt = S_WSELF;
      end
      S_WSELF: begin
        pidx_nxt  = '0;
        state_nxt = S_PRD;
      end
      S_PRD: begin
        if (patch_r[pidx_r].valid) begin
          state_nxt = S_PWR;
        end else if (pidx_r == 2'd2) begin
          state_nxt = S_DONE;
        end else begin
          pidx_nxt = pidx_r + 2'd1;
        end
      end
      S_PWR: begin
        if (pidx_r == 2'd2) begin
          state_nxt = S_DONE;
        end else begin
          pidx_nxt  = pidx_r + 2'd1;
          state_nxt = S_PRD;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_chunk_nxt  = chunk_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      next_unused_r <= '0;
      empty_head_r  <= NIL;
      full_head_r   <= NIL;
      out_valid_r   <= 1'b0;
      pidx_r        <= '0;
      for (int k = 0; k < NUM_CLASSES; k++) class_head_r[k] <= NIL;
      for (int k = 0; k < 3; k++) patch_r[k] <= '0;
    end else begin
      state_r       <= state_nxt;
      next_unused_r <= next_unused_nxt;
      empty_head_r  <= empty_head_nxt;
      full_head_r   <= full_head_nxt;
      out_valid_r   <= out_valid_nxt;
      pidx_r        <= pidx_nxt;
      for (int k = 0; k < NUM_CLASSES; k++) class_head_r[k] <= class_head_nxt[k];
      for (int k = 0; k < 3; k++) patch_r[k] <= patch_nxt[k];
    end
    if (state_r == S_IDLE && in_valid) begin
      op_r   <= in_op;
      size_r <= in_alloc_size;
      off_r  <= in_free_offset;
    end
    blk_r        <= blk_nxt;
    cls_r        <= cls_nxt;
    fresh_r      <= fresh_nxt;
    meta_r       <= meta_nxt;
    bm_r         <= bm_nxt;
    status_r     <= status_nxt;
    chunk_r      <= chunk_nxt;
    out_status_r <= out_status_nxt;
    out_chunk_r  <= out_chunk_nxt;
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_chunk_offset = out_chunk_r;

  `SCA_ASSERT_NEXT(a_done_shows_result, clk, rst_n,
    (state_r == S_DONE) && (!out_valid_r || !out_stall), out_valid_r && (state_r == S_IDLE))
  `SCA_ASSERT_IMPLY(a_scan_done_in_scan, clk, rst_n, scan_res.done, state_r == S_SCAN)
  `SCA_ASSERT_IMPLY(a_patch_write_valid, clk, rst_n, state_r == S_PWR, patch_r[pidx_r].valid)
  `SCA_ASSERT_IMPLY(a_bump_in_range, clk, rst_n, 1'b1, next_unused_r <= PTR_W'(MAX_BLOCKS))

endmodule

FILE: bench/slab_chunk_allocator_tb.sv
// Self-checking testbench for slab_chunk_allocator: allocate and free items
// are checked against an in-bench allocator model. Depends on sca_pkg and slab_chunk_allocator.
module slab_chunk_allocator_tb;
  import sca_pkg::*;

  localparam logic [2:0] ST_BUMP_INITED = 3'd3;
  localparam logic       OP_ALLOC = 1'b0;
  localparam logic       OP_FREE  = 1'b1;
  localparam int NONE = -1;
  localparam int EMPTY_LIST = NUM_CLASSES;
  localparam int FULL_LIST  = NUM_CLASSES + 1;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE = 40;

  typedef enum int {IDLE_SENDER, IDLE_RECEIVER, IDLE_NONE} idle_mode_e;

  typedef struct {
    logic        op;
    logic [16:0] size;
    logic [25:0] offset;
  } request_t;

  typedef struct {
    logic [2:0]  status;
    logic [25:0] offset;
  } reply_t;

  typedef struct {
    int off;
    int cshift;
  } chunk_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_op = 1'b0;
  logic [16:0] in_alloc_size = '0;
  logic [25:0] in_free_offset = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [25:0] out_chunk_offset;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  slab_chunk_allocator DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_alloc_size(in_alloc_size), .in_free_offset(in_free_offset),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_chunk_offset(out_chunk_offset),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Allocator model state.
  int        shadow_bs = 12, shadow_mcs = 5, shadow_count = 1024;
  int        g_bs, g_mcs, g_nblk;
  logic [3:0]   blk_cls [MAX_BLOCKS];
  bit           blk_inited [MAX_BLOCKS];
  bit           blk_full [MAX_BLOCKS];
  logic [255:0] blk_map [MAX_BLOCKS];
  int           blk_prev [MAX_BLOCKS];
  int           blk_next [MAX_BLOCKS];
  int           list_head [NUM_CLASSES + 2];
  int           bump_ptr = 0;

  request_t pending_items[$];
  reply_t   pending_replies[$];
  reply_t   awaited_replies[$];
  chunk_t   live_chunks[$];

  idle_mode_e idle_mode = IDLE_SENDER;
  int  errors = 0;
  int  cycles = 0;
  int  taken_count = 0;
  bit  taken = 1'b0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  function automatic bit is_blk(int p);
    return p >= 0 && p < MAX_BLOCKS;
  endfunction

  function automatic void update_geometry();
    int bs, mcs, n;
    bs = shadow_bs; mcs = shadow_mcs; n = shadow_count;
    if (bs < 3) bs = 3;
    if (bs > 16) bs = 16;
    if (mcs < 3) mcs = 3;
    if (mcs > bs) mcs = bs;
    if (bs - mcs > 8) mcs = bs - 8;
    if (n < 1) n = 1;
    if (n > MAX_BLOCKS) n = MAX_BLOCKS;
    g_bs = bs; g_mcs = mcs; g_nblk = n;
  endfunction

  function automatic int clamp_class(int c);
    int top;
    top = g_bs - g_mcs;
    if (top > NUM_CLASSES - 1) top = NUM_CLASSES - 1;
    return c > top ? top : c;
  endfunction

  function automatic int chunks_in_block(int c);
    int n;
    n = 1 << (g_bs - g_mcs - c);
    return n > MAX_CHUNKS ? MAX_CHUNKS : n;
  endfunction

  function automatic void unlink_block(int b, int lst);
    int p, n;
    p = blk_prev[b]; n = blk_next[b];
    if (is_blk(p)) blk_next[p] = n; else list_head[lst] = n;
    if (is_blk(n)) blk_prev[n] = p;
  endfunction

  function automatic void push_block(int b, int lst);
    blk_prev[b] = NONE;
    blk_next[b] = list_head[lst];
    list_head[lst] = b;
    if (is_blk(blk_next[b])) blk_prev[blk_next[b]] = b;
  endfunction

  function automatic void start_block(int b, int c);
    blk_cls[b] = 4'(c);
    blk_inited[b] = 1'b1;
    blk_full[b] = 1'b0;
    blk_map[b] = '0;
    blk_prev[b] = NONE;
    blk_next[b] = NONE;
    push_block(b, c);
  endfunction

  function automatic int grab_chunk(int b, int c);
    int n, pick, nx;
    bit full;
    n = chunks_in_block(c);
    pick = n;
    full = 1'b1;
    for (int j = 0; j < n; j++)
      if (!blk_map[b][j]) begin
        pick = j;
        break;
      end
    if (pick == n) pick = 0;
    blk_map[b][pick] = 1'b1;
    for (int j = 0; j < n; j++)
      if (!blk_map[b][j]) begin
        full = 1'b0;
        break;
      end
    if (full) begin
      nx = blk_next[b];
      blk_full[b] = 1'b1;
      list_head[c] = nx;
      if (is_blk(nx)) blk_prev[nx] = NONE;
      blk_next[b] = list_head[FULL_LIST];
      if (is_blk(list_head[FULL_LIST])) blk_prev[list_head[FULL_LIST]] = b;
      blk_prev[b] = NONE;
      list_head[FULL_LIST] = b;
    end
    return ((b << g_bs) + (pick << (g_mcs + c))) & 32'h3FFFFFF;
  endfunction

  function automatic reply_t predict_alloc(int size, output int cshift);
    reply_t r;
    int i, c, b;
    r.offset = '0;
    cshift = 0;
    if (size == 0 || size > (1 << g_bs)) begin
      r.status = ST_BAD_SIZE;
      return r;
    end
    c = 0;
    i = (size - 1) >> (g_mcs - 1);
    i = i >> 1;
    while (i != 0) begin
      c++;
      i = i >> 1;
    end
    c = clamp_class(c);
    if (is_blk(list_head[c])) begin
      b = list_head[c];
    end else if (is_blk(list_head[EMPTY_LIST])) begin
      b = list_head[EMPTY_LIST];
      list_head[EMPTY_LIST] = blk_next[b];
      if (is_blk(list_head[EMPTY_LIST])) blk_prev[list_head[EMPTY_LIST]] = NONE;
      start_block(b, c);
    end else if (bump_ptr < g_nblk) begin
      b = bump_ptr;
      bump_ptr++;
      if (blk_inited[b]) begin
        r.status = ST_BUMP_INITED;
        return r;
      end
      start_block(b, c);
    end else begin
      r.status = ST_NO_BLOCK;
      return r;
    end
    r.offset = 26'(grab_chunk(b, c));
    r.status = ST_OK;
    cshift = g_mcs + c;
    return r;
  endfunction

  function automatic reply_t predict_free(int off);
    reply_t r;
    int b, c, n, j;
    bit was_full, empty;
    r.offset = '0;
    b = off >> g_bs;
    if (b >= bump_ptr || !is_blk(b)) begin
      r.status = ST_FREE_RANGE;
      return r;
    end
    c = clamp_class(blk_cls[b]);
    n = chunks_in_block(c);
    j = (off - (b << g_bs)) >> (g_mcs + c);
    was_full = blk_full[b];
    blk_full[b] = 1'b0;
    if (j < n) blk_map[b][j] = 1'b0;
    empty = 1'b1;
    for (int k = 0; k < n; k++)
      if (blk_map[b][k]) begin
        empty = 1'b0;
        break;
      end
    if (was_full && empty) begin
      unlink_block(b, FULL_LIST);
      push_block(b, EMPTY_LIST);
    end else if (was_full) begin
      unlink_block(b, FULL_LIST);
      push_block(b, c);
    end else if (empty) begin
      unlink_block(b, c);
      push_block(b, EMPTY_LIST);
    end
    r.status = ST_OK;
    return r;
  endfunction

  // Each item is predicted as it is queued; items are accepted in queue order.
  task automatic queue_alloc(int size);
    request_t q;
    chunk_t ch;
    int cs;
    q.op = OP_ALLOC; q.size = 17'(size); q.offset = 26'($urandom);
    update_geometry();
    pending_replies.push_back(predict_alloc(size, cs));
    pending_items.push_back(q);
    if (pending_replies[$].status == ST_OK) begin
      ch.off = int'(pending_replies[$].offset);
      ch.cshift = cs;
      live_chunks.push_back(ch);
    end
  endtask

  task automatic queue_free(int off);
    request_t q;
    q.op = OP_FREE; q.size = 17'($urandom); q.offset = 26'(off);
    update_geometry();
    pending_replies.push_back(predict_free(off));
    pending_items.push_back(q);
  endtask

  task automatic free_live(int idx);
    chunk_t ch;
    ch = live_chunks[idx];
    live_chunks.delete(idx);
    queue_free(ch.off + $urandom_range(0, (1 << ch.cshift) - 1));
  endtask

  // Offset whose block lies above the bump pointer; falls back to a bad size.
  task automatic queue_stray_free();
    int off;
    update_geometry();
    if ((1 << (26 - g_bs)) <= bump_ptr) begin
      queue_alloc(0);
    end else begin
      do off = $urandom & 32'h3FFFFFF; while ((off >> g_bs) < bump_ptr);
      queue_free(off);
    end
  endtask

  task automatic run_random(int count);
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      update_geometry();
      if (r < 4) queue_alloc($urandom_range(g_bs < 16 ? (1 << g_bs) + 1 : 65536, 65536));
      else if (r < 8) queue_stray_free();
      else if (r < 10) queue_alloc(0);
      else if (live_chunks.size() > 0 && (r < 45 || live_chunks.size() > 48))
        free_live($urandom_range(0, live_chunks.size() - 1));
      else queue_alloc($urandom_range(1, 1 << $urandom_range(0, g_bs)));
    end
    while (live_chunks.size() > 0) free_live($urandom_range(0, live_chunks.size() - 1));
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || awaited_replies.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int value);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_BLOCK_SHIFT:     shadow_bs = value & 31;
      REG_MIN_CHUNK_SHIFT: shadow_mcs = value & 31;
      default:             shadow_count = value & 2047;
    endcase
  endtask

  task automatic configure(int bs, int mcs, int count);
    write_reg(REG_BLOCK_SHIFT, bs);
    write_reg(REG_MIN_CHUNK_SHIFT, mcs);
    write_reg(REG_BLOCK_COUNT, count);
  endtask

  initial begin
    for (int b = 0; b < MAX_BLOCKS; b++) begin
      blk_cls[b] = '0; blk_inited[b] = 1'b0; blk_full[b] = 1'b0;
      blk_map[b] = '0; blk_prev[b] = NONE; blk_next[b] = NONE;
    end
    foreach (list_head[i]) list_head[i] = NONE;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Size edges of the lowest class boundaries, the largest size, and frees of
    // both a live chunk and a block above the bump pointer.
    queue_alloc(0);
    queue_alloc(1);
    queue_alloc(32);
    queue_alloc(33);
    queue_alloc(64);
    queue_alloc(4095);
    queue_alloc(4096);
    queue_alloc(4097);
    queue_alloc(65536);
    queue_free(26'h3FFFFFF);
    queue_free(0);
    free_live(0);
    for (int k = 0; k < 8; k++) queue_alloc(4096);
    run_random(150);
    wait_drained();

    configure(3, 3, 1);
    run_random(150);
    wait_drained();
    configure(8, 5, 6);
    run_random(170);
    wait_drained();
    idle_mode = IDLE_RECEIVER;
    configure(16, 8, 1024);
    run_random(150);
    wait_drained();
    configure(0, 31, 0);
    run_random(130);
    wait_drained();
    idle_mode = IDLE_NONE;
    configure(9, 0, 2047);
    run_random(170);
    wait_drained();
    configure(16, 3, 3);
    run_random(150);
    wait_drained();

    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    taken = rst_n && in_valid && !in_stall;
    if (taken) begin
      awaited_replies.push_back(pending_replies.pop_front());
      taken_count++;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_replies.size() == 0) begin
        errors++;
        $display("%0t: unexpected result status %0d offset %h",
                 $realtime, out_status, out_chunk_offset);
      end else begin
        reply_t e;
        e = awaited_replies.pop_front();
        if (out_status !== e.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $realtime, e.status, out_status);
        end
        if (out_chunk_offset !== e.offset) begin
          errors++;
          $display("%0t: chunk offset expected %h actual %h",
                   $realtime, e.offset, out_chunk_offset);
        end
      end
    end
  end

  // Input driver: the payload only moves once the current item is taken.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || taken)) begin
      if (pending_items.size() > 0 &&
          !(idle_mode == IDLE_SENDER && $urandom_range(0, 99) < 26) &&
          !(idle_mode == IDLE_RECEIVER && $urandom_range(0, 99) < 49)) begin
        request_t q;
        q = pending_items.pop_front();
        in_valid <= 1'b1;
        in_op <= q.op;
        in_alloc_size <= q.size;
        in_free_offset <= q.offset;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result stall, with one long hold-off early on so the block backs up.
  always @(negedge clk) begin
    if (!hold_done && taken_count >= 40) begin
      hold_done = 1'b1;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (idle_mode == IDLE_SENDER) begin
      out_stall <= $urandom_range(0, 99) < 49;
    end else if (idle_mode == IDLE_RECEIVER) begin
      out_stall <= $urandom_range(0, 99) < 26;
    end else begin
      out_stall <= 1'b0;
    end
  end

endmodule
